// ===== rtl/mersenne_twister_generator_top_defines.svh =====
// Assertion macros for the MT19937 generator
`ifndef MERSENNE_TWISTER_GENERATOR_TOP_DEFINES_SVH
`define MERSENNE_TWISTER_GENERATOR_TOP_DEFINES_SVH

// check that cond holds at every edge out of reset
`define MTG_ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("mtg check failed");

// check that pre implies post at the same edge
`define MTG_ASSERT_IMPL(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("mtg check failed");

`endif

// ===== rtl/mtg_pkg.sv =====
// Types and constants shared by the MT19937 generator
package mtg_pkg;
	localparam int unsigned STATE_LEN    = 624;
	localparam int unsigned TWIST_OFFSET = 397;
	localparam int unsigned IDX_W        = 10;

	localparam logic [IDX_W-1:0] IDX_LAST      = 10'd623;
	localparam logic [IDX_W-1:0] IDX_END       = 10'd624;
	localparam logic [IDX_W-1:0] IDX_UNSEEDED  = 10'd625;
	localparam logic [IDX_W-1:0] FAR_WRAP      = 10'd227;
	localparam logic [IDX_W-1:0] FAR_OFFSET    = 10'd397;

	localparam logic [31:0] TWIST_MATRIX = 32'h9908b0df;
	localparam logic [31:0] HIGH_BIT     = 32'h80000000;
	localparam logic [31:0] LOW_BITS     = 32'h7fffffff;
	localparam logic [31:0] TEMPER_B     = 32'h9d2c5680;
	localparam logic [31:0] TEMPER_C     = 32'hefc60000;
	localparam logic [31:0] MUL_LINEAR   = 32'd1812433253;
	localparam logic [31:0] MUL_ARRAY1   = 32'd1664525;
	localparam logic [31:0] MUL_ARRAY2   = 32'd1566083941;
	localparam logic [31:0] SEED_ARRAY   = 32'd19650218;
	localparam logic [31:0] SEED_DEFAULT = 32'd5489;

	typedef enum logic [1:0] {
		FUNC_DRAW   = 2'd0,
		FUNC_RESEED = 2'd1,
		FUNC_KEY    = 2'd2,
		FUNC_NONE   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		PURP_RESEED,
		PURP_DRAW,
		PURP_ARRAY
	} purpose_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DRAW_RD,
		ST_DRAW_OUT,
		ST_SL_INIT,
		ST_SL_MUL,
		ST_SL_WR,
		ST_TW_INIT,
		ST_TW_A,
		ST_TW_B,
		ST_TW_C,
		ST_SA_RD,
		ST_SA_MUL,
		ST_SA_WR,
		ST_SA_WRAP,
		ST_SA_FIN
	} state_t;

	// state memory port request
	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		logic [31:0]      wdata;
		logic             re;
		logic [IDX_W-1:0] raddr;
	} mem_req_t;
endpackage

// ===== rtl/mtg_state_ram.sv =====
// 624-word state memory, one write and one registered read per cycle
module mtg_state_ram (
	input  logic              clk,
	input  mtg_pkg::mem_req_t req,
	output logic [31:0]       rdata
);
	logic [31:0] mem [mtg_pkg::STATE_LEN];

	// write port
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	// registered read port, held when idle
	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end
endmodule

// ===== rtl/mtg_key_ram.sv =====
// Key word buffer with a registered read port
module mtg_key_ram #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned AW    = 4
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rdata
);
	logic [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== rtl/mtg_temper.sv =====
// Output tempering of one state word
module mtg_temper (
	input  logic [31:0] word_in,
	output logic [31:0] word_out
);
	logic [31:0] y1, y2, y3;

	// apply the four shift and mask steps
	always_comb begin
		y1       = word_in ^ (word_in >> 11);
		y2       = y1 ^ ((y1 << 7) & mtg_pkg::TEMPER_B);
		y3       = y2 ^ ((y2 << 15) & mtg_pkg::TEMPER_C);
		word_out = y3 ^ (y3 >> 18);
	end
endmodule

// ===== rtl/mersenne_twister_generator_top.sv =====
// Draw: ST_DRAW_RD reads the word and ST_DRAW_OUT tempers it into the output, waiting
// while a stalled result holds it; a new request can be taken as the word is offered.
// A draw past the end first runs a full twist of 624 words, each through ST_TW_A,
// ST_TW_B and ST_TW_C on the single read port. Reseed: linear seeding of 624 words.
// Array seeding: linear seeding plus 1247 words (plus wraps). One item at a time.
// Reset clears the control state and marks the generator unseeded; a draw then seeds
// with 5489. State memory and key buffer contents are undefined until written.
module mersenne_twister_generator_top #(
	parameter int unsigned MAX_KEY_WORDS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [31:0] key_word,
	input  logic        key_last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] random_word
);
	`include "mersenne_twister_generator_top_defines.svh"

	localparam int unsigned KA_W = (MAX_KEY_WORDS > 1) ? $clog2(MAX_KEY_WORDS) : 1;
	localparam int unsigned KC_W = $clog2(MAX_KEY_WORDS + 1);
	localparam logic [KC_W-1:0] KEY_MAX = KC_W'(MAX_KEY_WORDS);
	localparam int unsigned IW = mtg_pkg::IDX_W;

	mtg_pkg::state_t   state_q, state_d;
	mtg_pkg::purpose_t purpose_q;
	mtg_pkg::mem_req_t mem_req;

	logic [31:0]   seed_q;
	logic [IW-1:0] idx_q;
	logic [IW-1:0] n_q;
	logic [IW-1:0] k_q;
	logic [KA_W-1:0] j_q;
	logic [KC_W-1:0] key_count_q, len_q, count_new;
	logic          phase_q;
	logic [31:0]   prev_q, prod_q, cur_q, nxt_q;
	logic [31:0]   rdata, key_rdata, tempered;
	logic [31:0]   mul_b, sl_word, sa_word, tw_word, y_tw;
	logic [31:0]   mul_lo;
	logic [IW-1:0] far_idx, nxt_idx;
	logic          out_valid_q;
	logic [31:0]   random_word_q;
	logic          in_acc, key_we, key_re, out_free;

	assign in_stall    = (state_q != mtg_pkg::ST_IDLE);
	assign in_acc      = in_valid && !in_stall;
	assign out_valid   = out_valid_q;
	assign random_word = random_word_q;
	assign out_free    = !out_valid_q || !out_stall;

	mtg_state_ram u_state_ram (
		.clk   (clk),
		.req   (mem_req),
		.rdata (rdata)
	);

	mtg_key_ram #(
		.DEPTH (MAX_KEY_WORDS),
		.AW    (KA_W)
	) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (key_count_q[KA_W-1:0]),
		.wdata (key_word),
		.re    (key_re),
		.raddr (j_q),
		.rdata (key_rdata)
	);

	mtg_temper u_temper (
		.word_in  (rdata),
		.word_out (tempered)
	);

	// store a key word while the buffer has room
	assign key_we = in_acc && (mtg_pkg::func_t'(func) == mtg_pkg::FUNC_KEY)
		&& (key_count_q < KEY_MAX);
	assign count_new = (key_count_q < KEY_MAX) ? key_count_q + KC_W'(1) : key_count_q;
	assign key_re = (state_q == mtg_pkg::ST_SA_RD);

	// shared multiplier operands, low half of the product only
	always_comb begin
		case (state_q)
			mtg_pkg::ST_SL_MUL: mul_b = mtg_pkg::MUL_LINEAR;
			mtg_pkg::ST_SA_MUL: mul_b = phase_q ? mtg_pkg::MUL_ARRAY2 : mtg_pkg::MUL_ARRAY1;
			default:            mul_b = mtg_pkg::MUL_LINEAR;
		endcase
	end
	assign mul_lo = (prev_q ^ (prev_q >> 30)) * mul_b;

	// words written by each procedure
	assign sl_word = prod_q + {22'd0, n_q};
	assign sa_word = phase_q ? ((rdata ^ prod_q) - {22'd0, n_q})
		: ((rdata ^ prod_q) + key_rdata + 32'(j_q));
	assign y_tw    = (cur_q & mtg_pkg::HIGH_BIT) | (nxt_q & mtg_pkg::LOW_BITS);
	assign tw_word = rdata ^ (y_tw >> 1) ^ (y_tw[0] ? mtg_pkg::TWIST_MATRIX : 32'd0);

	// neighbour indexes for the twist
	assign nxt_idx = (n_q == mtg_pkg::IDX_LAST) ? '0 : n_q + IW'(1);
	assign far_idx = (n_q < mtg_pkg::FAR_WRAP) ? n_q + mtg_pkg::FAR_OFFSET
		: n_q - mtg_pkg::FAR_WRAP;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mtg_pkg::ST_IDLE: begin
				if (in_acc) begin
					case (mtg_pkg::func_t'(func))
						mtg_pkg::FUNC_DRAW: begin
							if (idx_q < mtg_pkg::IDX_END) begin
								state_d = mtg_pkg::ST_DRAW_RD;
							end else if (idx_q == mtg_pkg::IDX_UNSEEDED) begin
								state_d = mtg_pkg::ST_SL_INIT;
							end else begin
								state_d = mtg_pkg::ST_TW_INIT;
							end
						end
						mtg_pkg::FUNC_RESEED: state_d = mtg_pkg::ST_SL_INIT;
						mtg_pkg::FUNC_KEY: begin
							if (key_last) begin
								state_d = mtg_pkg::ST_SL_INIT;
							end
						end
						default: state_d = mtg_pkg::ST_IDLE;
					endcase
				end
			end
			mtg_pkg::ST_DRAW_RD:  state_d = mtg_pkg::ST_DRAW_OUT;
			mtg_pkg::ST_DRAW_OUT: begin
				if (out_free) begin
					state_d = mtg_pkg::ST_IDLE;
				end
			end
			mtg_pkg::ST_SL_INIT: state_d = mtg_pkg::ST_SL_MUL;
			mtg_pkg::ST_SL_MUL:  state_d = mtg_pkg::ST_SL_WR;
			mtg_pkg::ST_SL_WR: begin
				if (n_q == mtg_pkg::IDX_LAST) begin
					case (purpose_q)
						mtg_pkg::PURP_DRAW:  state_d = mtg_pkg::ST_TW_INIT;
						mtg_pkg::PURP_ARRAY: state_d = mtg_pkg::ST_SA_RD;
						default:             state_d = mtg_pkg::ST_IDLE;
					endcase
				end else begin
					state_d = mtg_pkg::ST_SL_MUL;
				end
			end
			mtg_pkg::ST_TW_INIT: state_d = mtg_pkg::ST_TW_A;
			mtg_pkg::ST_TW_A:    state_d = mtg_pkg::ST_TW_B;
			mtg_pkg::ST_TW_B:    state_d = mtg_pkg::ST_TW_C;
			mtg_pkg::ST_TW_C: begin
				state_d = (n_q == mtg_pkg::IDX_LAST) ? mtg_pkg::ST_DRAW_RD : mtg_pkg::ST_TW_A;
			end
			mtg_pkg::ST_SA_RD:  state_d = mtg_pkg::ST_SA_MUL;
			mtg_pkg::ST_SA_MUL: state_d = mtg_pkg::ST_SA_WR;
			mtg_pkg::ST_SA_WR: begin
				if (n_q == mtg_pkg::IDX_LAST) begin
					state_d = mtg_pkg::ST_SA_WRAP;
				end else if (k_q == IW'(1) && phase_q) begin
					state_d = mtg_pkg::ST_SA_FIN;
				end else begin
					state_d = mtg_pkg::ST_SA_RD;
				end
			end
			mtg_pkg::ST_SA_WRAP: begin
				state_d = (k_q == '0 && phase_q) ? mtg_pkg::ST_SA_FIN : mtg_pkg::ST_SA_RD;
			end
			mtg_pkg::ST_SA_FIN: state_d = mtg_pkg::ST_IDLE;
			default:            state_d = mtg_pkg::ST_IDLE;
		endcase
	end

	// state memory port
	always_comb begin
		mem_req = '0;
		case (state_q)
			mtg_pkg::ST_DRAW_RD: begin
				mem_req.re    = 1'b1;
				mem_req.raddr = idx_q;
			end
			mtg_pkg::ST_SL_INIT: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = '0;
				case (purpose_q)
					mtg_pkg::PURP_DRAW:  mem_req.wdata = mtg_pkg::SEED_DEFAULT;
					mtg_pkg::PURP_ARRAY: mem_req.wdata = mtg_pkg::SEED_ARRAY;
					default:             mem_req.wdata = seed_q;
				endcase
			end
			mtg_pkg::ST_SL_WR: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = n_q;
				mem_req.wdata = sl_word;
			end
			mtg_pkg::ST_TW_INIT: begin
				mem_req.re    = 1'b1;
				mem_req.raddr = '0;
			end
			mtg_pkg::ST_TW_A: begin
				mem_req.re    = 1'b1;
				mem_req.raddr = nxt_idx;
			end
			mtg_pkg::ST_TW_B: begin
				mem_req.re    = 1'b1;
				mem_req.raddr = far_idx;
			end
			mtg_pkg::ST_TW_C: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = n_q;
				mem_req.wdata = tw_word;
			end
			mtg_pkg::ST_SA_RD: begin
				mem_req.re    = 1'b1;
				mem_req.raddr = n_q;
			end
			mtg_pkg::ST_SA_WR: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = n_q;
				mem_req.wdata = sa_word;
			end
			mtg_pkg::ST_SA_WRAP: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = '0;
				mem_req.wdata = prev_q;
			end
			mtg_pkg::ST_SA_FIN: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = '0;
				mem_req.wdata = mtg_pkg::HIGH_BIT;
			end
			default: mem_req = '0;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mtg_pkg::ST_IDLE;
			purpose_q   <= mtg_pkg::PURP_RESEED;
			seed_q      <= mtg_pkg::SEED_DEFAULT;
			idx_q       <= mtg_pkg::IDX_UNSEEDED;
			key_count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				seed_q <= cfg_wdata;
			end
			// load a fresh result, or drop the one taken
			if (state_q == mtg_pkg::ST_DRAW_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == mtg_pkg::ST_IDLE && in_acc) begin
				case (mtg_pkg::func_t'(func))
					mtg_pkg::FUNC_DRAW:   purpose_q <= mtg_pkg::PURP_DRAW;
					mtg_pkg::FUNC_RESEED: purpose_q <= mtg_pkg::PURP_RESEED;
					mtg_pkg::FUNC_KEY: begin
						purpose_q   <= mtg_pkg::PURP_ARRAY;
						key_count_q <= count_new;
					end
					default: purpose_q <= purpose_q;
				endcase
			end
			if (state_q == mtg_pkg::ST_DRAW_RD) begin
				idx_q <= idx_q + IW'(1);
			end
			if (state_q == mtg_pkg::ST_SL_WR && n_q == mtg_pkg::IDX_LAST) begin
				idx_q <= mtg_pkg::IDX_END;
			end
			if (state_q == mtg_pkg::ST_TW_C && n_q == mtg_pkg::IDX_LAST) begin
				idx_q <= '0;
			end
			if (state_q == mtg_pkg::ST_SA_FIN) begin
				idx_q       <= mtg_pkg::IDX_END;
				key_count_q <= '0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			mtg_pkg::ST_IDLE: begin
				len_q <= count_new;
			end
			mtg_pkg::ST_DRAW_OUT: begin
				if (out_free) begin
					random_word_q <= tempered;
				end
			end
			mtg_pkg::ST_SL_INIT: begin
				n_q <= IW'(1);
				case (purpose_q)
					mtg_pkg::PURP_DRAW:  prev_q <= mtg_pkg::SEED_DEFAULT;
					mtg_pkg::PURP_ARRAY: prev_q <= mtg_pkg::SEED_ARRAY;
					default:             prev_q <= seed_q;
				endcase
			end
			mtg_pkg::ST_SL_MUL: begin
				prod_q <= mul_lo;
			end
			mtg_pkg::ST_SL_WR: begin
				// set up array seeding from the first word
				if (n_q == mtg_pkg::IDX_LAST) begin
					prev_q  <= mtg_pkg::SEED_ARRAY;
					n_q     <= IW'(1);
					j_q     <= '0;
					k_q     <= mtg_pkg::IDX_END;
					phase_q <= 1'b0;
				end else begin
					prev_q <= sl_word;
					n_q    <= n_q + IW'(1);
				end
			end
			mtg_pkg::ST_TW_INIT: begin
				n_q <= '0;
			end
			mtg_pkg::ST_TW_A: begin
				if (n_q == '0) begin
					cur_q <= rdata;
				end
			end
			mtg_pkg::ST_TW_B: begin
				nxt_q <= rdata;
			end
			mtg_pkg::ST_TW_C: begin
				cur_q <= nxt_q;
				n_q   <= n_q + IW'(1);
			end
			mtg_pkg::ST_SA_MUL: begin
				prod_q <= mul_lo;
			end
			mtg_pkg::ST_SA_WR: begin
				prev_q <= sa_word;
				n_q    <= n_q + IW'(1);
				if (!phase_q) begin
					j_q <= (KC_W'(j_q) >= len_q - KC_W'(1)) ? '0 : j_q + KA_W'(1);
				end
				// end of phase one starts phase two
				if (k_q == IW'(1) && !phase_q) begin
					phase_q <= 1'b1;
					k_q     <= mtg_pkg::IDX_LAST;
				end else begin
					k_q <= k_q - IW'(1);
				end
			end
			mtg_pkg::ST_SA_WRAP: begin
				n_q <= IW'(1);
			end
			default: begin
				n_q <= n_q;
			end
		endcase
	end

	`MTG_ASSERT_IMPL(a_idle_no_write, state_q == mtg_pkg::ST_IDLE, !mem_req.we)
	`MTG_ASSERT_ALWAYS(a_key_count_bound, key_count_q <= KEY_MAX)
	`MTG_ASSERT_ALWAYS(a_idx_bound, idx_q <= mtg_pkg::IDX_UNSEEDED)
	`MTG_ASSERT_IMPL(a_read_write_apart, mem_req.we && mem_req.re, 1'b0)
endmodule
